FILE: rtl/issp_pkg.sv
// Shared types and constants for the serial programming vector master.
package issp_pkg;

  localparam int VectorBits = 22;
  localparam int VecIdxW    = $clog2(VectorBits);
  localparam int ReadInFirst = 11;
  localparam int ReadInEnd   = 21;

  localparam logic [7:0]  HalfBitReset = 8'd1;
  localparam logic [7:0]  PollReset    = 8'd10;
  localparam logic [15:0] RiseReset    = 16'd100;
  localparam logic [15:0] FallReset    = 16'd10000;

  typedef enum logic [2:0] {
    OpIdle  = 3'd0,
    OpWrite = 3'd1,
    OpRead  = 3'd2,
    OpZero  = 3'd3,
    OpPoll  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    PhIdle  = 4'd0,
    PhStart = 4'd1,
    PhOutHi = 4'd2,
    PhOutLo = 4'd3,
    PhInHi  = 4'd4,
    PhInLo  = 4'd5,
    PhRise  = 4'd6,
    PhFall  = 4'd7
  } phase_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StTimeout = 2'd1,
    StReject  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CfgHalfBit = 2'd0,
    CfgPoll    = 2'd1,
    CfgRise    = 2'd2,
    CfgFall    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] mode;
    logic       bank;
    logic [7:0] address;
    logic [7:0] write_data;
    logic       trail_bit;
    logic       sdata_in;
  } item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sdata_drive;
    logic       sdata_out;
    logic       sclk;
  } res_t;

endpackage

FILE: rtl/issp_engine.sv
// Pin-level engine: state, configuration and the single-pass step for one item.
module issp_engine #(
  parameter int TAIL_ZERO_BITS = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             en_i,
  input  issp_pkg::item_t  item_i,
  output issp_pkg::res_t   res_o
);

  localparam int CntMax = (TAIL_ZERO_BITS + 1 > issp_pkg::VectorBits) ?
                          TAIL_ZERO_BITS + 1 : issp_pkg::VectorBits;
  localparam int CntW   = $clog2(CntMax + 1);

  logic [7:0]  half_q, poll_q;
  logic [15:0] rise_q, fall_q;

  issp_pkg::op_e    operation_q, operation_d;
  issp_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]  bit_count_q, bit_count_d;
  logic [issp_pkg::VectorBits-1:0] shift_out_q, shift_out_d;
  logic [7:0]  shift_in_q, shift_in_d;
  logic [7:0]  tick_count_q, tick_count_d;
  logic [15:0] poll_count_q, poll_count_d;
  logic        sclk_q, sclk_d, data_q, data_d, drive_q, drive_d;

  logic [7:0]  half_eff, poll_eff;
  logic [15:0] rise_eff, fall_eff;
  logic        cmd, nb, ps, ps_rise, fail, fin;
  logic [15:0] pc_cur, pc_dec;
  logic [CntW-1:0] pos, total;
  logic [issp_pkg::VecIdxW-1:0] out_idx;
  logic        pos_in;
  issp_pkg::status_e st, fin_st;

  assign half_eff = (half_q == 8'd0) ? 8'd1 : half_q;
  assign poll_eff = (poll_q == 8'd0) ? 8'd1 : poll_q;
  assign rise_eff = (rise_q == 16'd0) ? 16'd1 : rise_q;
  assign fall_eff = (fall_q == 16'd0) ? 16'd1 : fall_q;

  assign cmd = (item_i.mode >= 3'(issp_pkg::OpWrite)) &&
               (item_i.mode <= 3'(issp_pkg::OpPoll));

  assign pos     = bit_count_q;
  assign total   = (operation_q == issp_pkg::OpPoll) ? CntW'(TAIL_ZERO_BITS + 1)
                                                     : CntW'(issp_pkg::VectorBits);
  assign out_idx = issp_pkg::VecIdxW'(issp_pkg::VectorBits - 1) -
                   pos[issp_pkg::VecIdxW-1:0];

  always_comb begin
    pos_in = 1'b0;
    case (operation_q)
      issp_pkg::OpRead: pos_in = (pos >= CntW'(issp_pkg::ReadInFirst)) &&
                                 (pos < CntW'(issp_pkg::ReadInEnd));
      issp_pkg::OpPoll: pos_in = (pos == '0);
      default:          pos_in = 1'b0;
    endcase
  end

  always_comb begin
    operation_d  = operation_q;
    phase_d      = phase_q;
    bit_count_d  = bit_count_q;
    shift_out_d  = shift_out_q;
    shift_in_d   = shift_in_q;
    tick_count_d = tick_count_q;
    poll_count_d = poll_count_q;
    sclk_d       = sclk_q;
    data_d       = data_q;
    drive_d      = drive_q;
    st           = issp_pkg::StOk;
    nb           = 1'b0;
    ps           = 1'b0;
    ps_rise      = 1'b0;
    pc_cur       = poll_count_q;
    fail         = 1'b0;
    fin          = 1'b0;
    fin_st       = issp_pkg::StOk;

    if (en_i) begin
      if (cmd) begin
        if (operation_q != issp_pkg::OpIdle) begin
          st = issp_pkg::StReject;
        end else begin
          operation_d  = issp_pkg::op_e'(item_i.mode);
          phase_d      = issp_pkg::PhStart;
          bit_count_d  = '0;
          tick_count_d = '0;
          poll_count_d = '0;
          case (item_i.mode)
            3'(issp_pkg::OpWrite): shift_out_d = {1'b1, item_i.bank, 1'b0, item_i.address,
                                                  item_i.write_data, {3{item_i.trail_bit}}};
            3'(issp_pkg::OpRead):  shift_out_d = {1'b1, item_i.bank, 1'b1, item_i.address,
                                                  10'd0, item_i.trail_bit};
            default:               shift_out_d = '0;
          endcase
        end
      end else begin
        case (phase_q)
          issp_pkg::PhStart: nb = 1'b1;
          issp_pkg::PhOutHi, issp_pkg::PhInHi: begin
            if (tick_count_q > 8'd1) begin
              tick_count_d = tick_count_q - 8'd1;
            end else begin
              phase_d      = (phase_q == issp_pkg::PhOutHi) ? issp_pkg::PhOutLo
                                                            : issp_pkg::PhInLo;
              sclk_d       = 1'b0;
              tick_count_d = half_eff;
            end
          end
          issp_pkg::PhOutLo: begin
            if (tick_count_q > 8'd1) tick_count_d = tick_count_q - 8'd1;
            else nb = 1'b1;
          end
          issp_pkg::PhInLo: begin
            if (tick_count_q > 8'd1) begin
              tick_count_d = tick_count_q - 8'd1;
            end else if (operation_q == issp_pkg::OpPoll && bit_count_q == CntW'(1)) begin
              sclk_d  = 1'b0;
              drive_d = 1'b0;
              data_d  = 1'b0;
              phase_d = issp_pkg::PhRise;
              ps      = 1'b1;
              ps_rise = 1'b1;
              pc_cur  = rise_eff;
            end else begin
              nb = 1'b1;
            end
          end
          issp_pkg::PhRise, issp_pkg::PhFall: begin
            if (tick_count_q > 8'd1) begin
              tick_count_d = tick_count_q - 8'd1;
            end else begin
              ps      = 1'b1;
              ps_rise = (phase_q == issp_pkg::PhRise);
            end
          end
          default: ;
        endcase
      end
    end

    // data line sample while polling; a rise also serves as first fall sample
    if (ps) begin
      if (ps_rise && !item_i.sdata_in) begin
        fail = 1'b1;
      end else begin
        if (ps_rise) begin
          phase_d = issp_pkg::PhFall;
          pc_cur  = fall_eff;
        end
        if (!item_i.sdata_in) nb = 1'b1;
        else fail = 1'b1;
      end
    end
    pc_dec = (pc_cur != 16'd0) ? pc_cur - 16'd1 : 16'd0;
    if (ps) poll_count_d = fail ? pc_dec : pc_cur;
    if (fail) begin
      if (pc_dec == 16'd0) begin
        fin    = 1'b1;
        fin_st = issp_pkg::StTimeout;
      end else begin
        tick_count_d = poll_eff;
      end
    end

    if (nb) begin
      if (pos >= total) begin
        fin    = 1'b1;
        fin_st = issp_pkg::StOk;
      end else begin
        if (pos_in) begin
          data_d  = 1'b0;
          drive_d = 1'b0;
          if (operation_q == issp_pkg::OpRead) shift_in_d = {shift_in_q[6:0], item_i.sdata_in};
          phase_d = issp_pkg::PhInHi;
        end else begin
          if (operation_q == issp_pkg::OpPoll || pos >= CntW'(issp_pkg::VectorBits)) begin
            data_d = 1'b0;
          end else begin
            data_d = shift_out_q[out_idx];
          end
          drive_d = 1'b1;
          phase_d = issp_pkg::PhOutHi;
        end
        sclk_d       = 1'b1;
        tick_count_d = half_eff;
        bit_count_d  = pos + CntW'(1);
      end
    end

    if (fin) begin
      operation_d = issp_pkg::OpIdle;
      phase_d     = issp_pkg::PhIdle;
      sclk_d      = 1'b0;
      data_d      = 1'b0;
      drive_d     = 1'b0;
      st          = fin_st;
    end
  end

  always_comb begin
    res_o.sclk        = sclk_d;
    res_o.sdata_out   = data_d;
    res_o.sdata_drive = drive_d;
    res_o.busy_res    = (operation_d != issp_pkg::OpIdle);
    res_o.done_res    = fin;
    res_o.read_data   = shift_in_d;
    res_o.status      = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= issp_pkg::HalfBitReset;
      poll_q <= issp_pkg::PollReset;
      rise_q <= issp_pkg::RiseReset;
      fall_q <= issp_pkg::FallReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        issp_pkg::CfgHalfBit: half_q <= cfg_data_i[7:0];
        issp_pkg::CfgPoll:    poll_q <= cfg_data_i[7:0];
        issp_pkg::CfgRise:    rise_q <= cfg_data_i;
        issp_pkg::CfgFall:    fall_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      operation_q  <= issp_pkg::OpIdle;
      phase_q      <= issp_pkg::PhIdle;
      bit_count_q  <= '0;
      shift_out_q  <= '0;
      shift_in_q   <= '0;
      tick_count_q <= '0;
      poll_count_q <= '0;
      sclk_q       <= 1'b0;
      data_q       <= 1'b0;
      drive_q      <= 1'b0;
    end else if (en_i) begin
      operation_q  <= operation_d;
      phase_q      <= phase_d;
      bit_count_q  <= bit_count_d;
      shift_out_q  <= shift_out_d;
      shift_in_q   <= shift_in_d;
      tick_count_q <= tick_count_d;
      poll_count_q <= poll_count_d;
      sclk_q       <= sclk_d;
      data_q       <= data_d;
      drive_q      <= drive_d;
    end
  end

endmodule

FILE: rtl/issp_vector_master.sv
// Tick-driven serial programming master: one result item for every command or tick item,
// one item per clock cycle sustained while the output is not stalled by m_axis_tready;
// an item is held in the input register, its result in the output register, and the whole
// step of the pin engine runs in a single pass between those two registers.
module issp_vector_master #(
  parameter int TAIL_ZERO_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // bank, address[8], write_data[8], trail_bit, sdata_in
  input  logic [2:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // sclk, sdata_out, sdata_drive, busy_res, done_res,
                                     // read_data[8], status[2]
);

  logic            in_valid_q, in_valid_d;
  issp_pkg::item_t in_item_q;
  logic            out_valid_q, out_valid_d;
  issp_pkg::res_t  out_q, res;
  logic            advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.mode       <= s_axis_tuser;
      in_item_q.bank       <= s_axis_tdata[0];
      in_item_q.address    <= s_axis_tdata[8:1];
      in_item_q.write_data <= s_axis_tdata[16:9];
      in_item_q.trail_bit  <= s_axis_tdata[17];
      in_item_q.sdata_in   <= s_axis_tdata[18];
    end
    if (advance) out_q <= res;
  end

  issp_engine #(
    .TAIL_ZERO_BITS(TAIL_ZERO_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .en_i       (advance),
    .item_i     (in_item_q),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

endmodule

FILE: rtl/issp_checker.sv
// Port-level checks for the vector master, bound to the top level.
module issp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
    else $error("done while still busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[14:13] != 2'd3)
    else $error("undefined status code");

  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3] |-> !m_axis_tdata[0] && !m_axis_tdata[2])
    else $error("pins active while idle");

  a_drive_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[2])
    else $error("data high while released");

endmodule

bind issp_vector_master issp_checker u_issp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
